### rtl/btms_pkg.sv
// Shared types, codes and the control store of the buzzer melody sequencer.
`timescale 1ns / 1ps
`default_nettype none

package btms_pkg;

    localparam int STEP_W = 5;
    typedef logic [STEP_W-1:0] step_t;

    localparam logic [2:0] KIND_TICK   = 3'd0;
    localparam logic [2:0] KIND_TONE   = 3'd1;
    localparam logic [2:0] KIND_MELODY = 3'd2;
    localparam logic [2:0] KIND_STOP   = 3'd3;
    localparam logic [2:0] KIND_LOAD   = 3'd4;

    localparam logic [15:0] WHOLE_NOTE_RESET = 16'd2000;
    localparam int          QUOT_W           = 16;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_FETCH,
        OP_READ,
        OP_NOTE_START,
        OP_DIV_STEP,
        OP_DUR_SET,
        OP_COUNT,
        OP_FINISH,
        OP_ADVANCE,
        OP_TONE,
        OP_MELODY,
        OP_STOP,
        OP_LOAD,
        OP_EMIT
    } op_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_ITEM,
        C_KIND_TONE,
        C_KIND_MELODY,
        C_KIND_STOP,
        C_KIND_LOAD,
        C_KIND_NOT_TICK,
        C_IDLE,
        C_SINGLE,
        C_NO_START,
        C_DIV_ZERO,
        C_DIV_MORE,
        C_NOT_OVER,
        C_LAST_NOTE,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ctrl_word_t;

    typedef struct packed {
        logic in_valid;
        logic kind_tick;
        logic kind_tone;
        logic kind_melody;
        logic kind_stop;
        logic kind_load;
        logic playing;
        logic melody_mode;
        logic start_next;
        logic div_zero;
        logic div_more;
        logic note_over;
        logic last_note;
        logic out_busy;
    } seq_status_t;

    localparam step_t STEP_FETCH      = 5'd0;
    localparam step_t STEP_NOTE_START = 5'd10;
    localparam step_t STEP_DIV        = 5'd11;
    localparam step_t STEP_TONE_TICK  = 5'd13;
    localparam step_t STEP_FINISH     = 5'd15;
    localparam step_t STEP_MEL_TICK   = 5'd16;
    localparam step_t STEP_TONE       = 5'd20;
    localparam step_t STEP_MELODY     = 5'd21;
    localparam step_t STEP_STOP       = 5'd22;
    localparam step_t STEP_LOAD       = 5'd23;
    localparam step_t STEP_EMIT       = 5'd24;

    function automatic ctrl_word_t ucode(input step_t addr);
        ctrl_word_t cw;
        unique case (addr)
            5'd0:  cw = '{OP_FETCH,      C_NO_ITEM,       STEP_FETCH};
            5'd1:  cw = '{OP_NONE,       C_KIND_TONE,     STEP_TONE};
            5'd2:  cw = '{OP_NONE,       C_KIND_MELODY,   STEP_MELODY};
            5'd3:  cw = '{OP_NONE,       C_KIND_STOP,     STEP_STOP};
            5'd4:  cw = '{OP_NONE,       C_KIND_LOAD,     STEP_LOAD};
            5'd5:  cw = '{OP_NONE,       C_KIND_NOT_TICK, STEP_EMIT};
            5'd6:  cw = '{OP_NONE,       C_IDLE,          STEP_EMIT};
            5'd7:  cw = '{OP_NONE,       C_SINGLE,        STEP_TONE_TICK};
            5'd8:  cw = '{OP_NONE,       C_NO_START,      STEP_MEL_TICK};
            5'd9:  cw = '{OP_READ,       C_NEVER,         STEP_FETCH};
            5'd10: cw = '{OP_NOTE_START, C_DIV_ZERO,      STEP_EMIT};
            5'd11: cw = '{OP_DIV_STEP,   C_DIV_MORE,      STEP_DIV};
            5'd12: cw = '{OP_DUR_SET,    C_ALWAYS,        STEP_EMIT};
            5'd13: cw = '{OP_COUNT,      C_NEVER,         STEP_FETCH};
            5'd14: cw = '{OP_NONE,       C_NOT_OVER,      STEP_EMIT};
            5'd15: cw = '{OP_FINISH,     C_ALWAYS,        STEP_EMIT};
            5'd16: cw = '{OP_COUNT,      C_NEVER,         STEP_FETCH};
            5'd17: cw = '{OP_NONE,       C_NOT_OVER,      STEP_EMIT};
            5'd18: cw = '{OP_NONE,       C_LAST_NOTE,     STEP_FINISH};
            5'd19: cw = '{OP_ADVANCE,    C_ALWAYS,        STEP_EMIT};
            5'd20: cw = '{OP_TONE,       C_ALWAYS,        STEP_EMIT};
            5'd21: cw = '{OP_MELODY,     C_ALWAYS,        STEP_EMIT};
            5'd22: cw = '{OP_STOP,       C_ALWAYS,        STEP_EMIT};
            5'd23: cw = '{OP_LOAD,       C_ALWAYS,        STEP_EMIT};
            5'd24: cw = '{OP_EMIT,       C_OUT_BUSY,      STEP_EMIT};
            5'd25: cw = '{OP_NONE,       C_ALWAYS,        STEP_FETCH};
            default: cw = '{OP_NONE,     C_ALWAYS,        STEP_FETCH};
        endcase
        return cw;
    endfunction

endpackage

`default_nettype wire

### rtl/btms_useq.sv
// Step counter and control store that sequence the melody datapath.
`timescale 1ns / 1ps
`default_nettype none

module btms_useq (
    input  logic                   clk,
    input  logic                   rst_n,
    input  btms_pkg::seq_status_t  status,
    output btms_pkg::op_t          op
);

    btms_pkg::step_t      pc_reg;
    btms_pkg::step_t      pc_next;
    btms_pkg::ctrl_word_t cw;
    logic                 take;

    always_comb
    begin
        cw = btms_pkg::ucode(pc_reg);
        unique case (cw.cond)
            btms_pkg::C_NEVER:         take = 1'b0;
            btms_pkg::C_ALWAYS:        take = 1'b1;
            btms_pkg::C_NO_ITEM:       take = !status.in_valid;
            btms_pkg::C_KIND_TONE:     take = status.kind_tone;
            btms_pkg::C_KIND_MELODY:   take = status.kind_melody;
            btms_pkg::C_KIND_STOP:     take = status.kind_stop;
            btms_pkg::C_KIND_LOAD:     take = status.kind_load;
            btms_pkg::C_KIND_NOT_TICK: take = !status.kind_tick;
            btms_pkg::C_IDLE:          take = !status.playing;
            btms_pkg::C_SINGLE:        take = !status.melody_mode;
            btms_pkg::C_NO_START:      take = !status.start_next;
            btms_pkg::C_DIV_ZERO:      take = status.div_zero;
            btms_pkg::C_DIV_MORE:      take = status.div_more;
            btms_pkg::C_NOT_OVER:      take = !status.note_over;
            btms_pkg::C_LAST_NOTE:     take = status.last_note;
            btms_pkg::C_OUT_BUSY:      take = status.out_busy;
            default:                   take = 1'b0;
        endcase
        pc_next = take ? cw.target : pc_reg + btms_pkg::step_t'(1);
        op      = cw.op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= btms_pkg::STEP_FETCH;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

### rtl/buzzer_tone_melody_sequencer_top.sv
// Top level of the buzzer tone and melody sequencer: datapath, melody store and control.
// Each kind of word takes its own path through the control store to out_valid; a tick that
// starts a note with a nonzero divider also runs the serial divider, which a zero divider skips.
// Throughput: one word at a time; the next word is taken once the step after the emit step
// has led back to the fetch step, and an unread result holds the sequencer. Reset clears all
// control state, sets the whole note to 2000 ms and leaves the melody store undefined; there is
// no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module buzzer_tone_melody_sequencer_top #(
    parameter int MELODY_DEPTH = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [15:0]        cfg_wr_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         kind,
    input  logic [15:0]        tone_frequency,
    input  logic [31:0]        tone_duration_ms,
    input  logic [7:0]         entry_index,
    input  logic [15:0]        note_freq,
    input  logic signed [7:0]  note_divider,
    input  logic [8:0]         melody_length,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               tone_on,
    output logic [15:0]        tone_hz,
    output logic               is_playing,
    output logic               done_pulse
);

    localparam int AW = (MELODY_DEPTH > 1) ? $clog2(MELODY_DEPTH) : 1;
    localparam int CW = AW + 1;

    btms_pkg::op_t         op;
    btms_pkg::seq_status_t status;

    logic [2:0]  kind_reg;
    logic [15:0] tone_freq_reg;
    logic [31:0] tone_dur_reg;
    logic [7:0]  idx_reg;
    logic [15:0] nfreq_reg;
    logic [7:0]  ndiv_reg;
    logic [8:0]  mlen_reg;

    logic          playing_reg;
    logic          melody_mode_reg;
    logic          start_next_reg;
    logic [AW-1:0] cursor_reg;
    logic [CW-1:0] count_reg;
    logic [31:0]   duration_reg;
    logic [31:0]   elapsed_reg;
    logic [15:0]   hz_reg;
    logic          drive_reg;
    logic          done_reg;
    logic [15:0]   whole_reg;

    logic [23:0]   mem [MELODY_DEPTH];
    logic [23:0]   rd_reg;

    logic [15:0]   quot_reg;
    logic [7:0]    rem_reg;
    logic [7:0]    divisor_reg;
    logic          neg_reg;
    logic [3:0]    step_cnt_reg;

    logic          out_valid_reg;
    logic          tone_on_reg;
    logic [15:0]   tone_hz_reg;
    logic          is_playing_reg;
    logic          done_pulse_reg;

    logic          accept;
    logic          out_busy;
    logic [8:0]    trial;
    logic          trial_ge;
    logic [7:0]    entry_div;
    logic [7:0]    entry_mag;
    logic [31:0]   len_sat;
    logic          idx_ok;

    btms_useq u_useq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .op     (op)
    );

    always_comb
    begin
        accept    = in_valid && (op == btms_pkg::OP_FETCH);
        in_stall  = (op != btms_pkg::OP_FETCH);
        out_busy  = out_valid_reg && out_stall;
        trial     = {rem_reg, quot_reg[btms_pkg::QUOT_W-1]};
        trial_ge  = (trial >= {1'b0, divisor_reg});
        entry_div = rd_reg[23:16];
        entry_mag = entry_div[7] ? 8'(8'd0 - entry_div) : entry_div;
        idx_ok    = (32'(idx_reg) < 32'(MELODY_DEPTH));
        if (mlen_reg == 9'd0)
        begin
            len_sat = 32'd1;
        end
        else if (32'(mlen_reg) > 32'(MELODY_DEPTH))
        begin
            len_sat = 32'(MELODY_DEPTH);
        end
        else
        begin
            len_sat = 32'(mlen_reg);
        end

        status.in_valid    = in_valid;
        status.kind_tick   = (kind_reg == btms_pkg::KIND_TICK);
        status.kind_tone   = (kind_reg == btms_pkg::KIND_TONE);
        status.kind_melody = (kind_reg == btms_pkg::KIND_MELODY);
        status.kind_stop   = (kind_reg == btms_pkg::KIND_STOP);
        status.kind_load   = (kind_reg == btms_pkg::KIND_LOAD);
        status.playing     = playing_reg;
        status.melody_mode = melody_mode_reg;
        status.start_next  = start_next_reg;
        status.div_zero    = (entry_div == 8'd0);
        status.div_more    = (step_cnt_reg != 4'd15);
        status.note_over   = (elapsed_reg > duration_reg);
        status.last_note   = (({1'b0, cursor_reg} + CW'(1)) == count_reg);
        status.out_busy    = out_busy;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg      <= kind;
            tone_freq_reg <= tone_frequency;
            tone_dur_reg  <= tone_duration_ms;
            idx_reg       <= entry_index;
            nfreq_reg     <= note_freq;
            ndiv_reg      <= $unsigned(note_divider);
            mlen_reg      <= melody_length;
        end
        if (op == btms_pkg::OP_LOAD && idx_ok)
        begin
            mem[AW'(idx_reg)] <= {ndiv_reg, nfreq_reg};
        end
        if (op == btms_pkg::OP_READ)
        begin
            rd_reg <= mem[cursor_reg];
        end
        if (op == btms_pkg::OP_NOTE_START)
        begin
            quot_reg     <= whole_reg;
            rem_reg      <= 8'd0;
            divisor_reg  <= entry_mag;
            neg_reg      <= entry_div[7];
            step_cnt_reg <= 4'd0;
        end
        if (op == btms_pkg::OP_DIV_STEP)
        begin
            quot_reg     <= {quot_reg[btms_pkg::QUOT_W-2:0], trial_ge};
            rem_reg      <= trial_ge ? 8'(trial - {1'b0, divisor_reg}) : trial[7:0];
            step_cnt_reg <= step_cnt_reg + 4'd1;
        end
        if (op == btms_pkg::OP_EMIT && !out_busy)
        begin
            tone_on_reg    <= drive_reg;
            tone_hz_reg    <= drive_reg ? hz_reg : 16'd0;
            is_playing_reg <= playing_reg;
            done_pulse_reg <= done_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            whole_reg       <= btms_pkg::WHOLE_NOTE_RESET;
            playing_reg     <= 1'b0;
            melody_mode_reg <= 1'b0;
            start_next_reg  <= 1'b0;
            cursor_reg      <= '0;
            count_reg       <= CW'(1);
            duration_reg    <= 32'd0;
            elapsed_reg     <= 32'd0;
            hz_reg          <= 16'd0;
            drive_reg       <= 1'b0;
            done_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                whole_reg <= cfg_wr_data;
            end
            if (op == btms_pkg::OP_EMIT && !out_busy)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (op)
                btms_pkg::OP_FETCH:
                begin
                    if (accept)
                    begin
                        done_reg <= 1'b0;
                    end
                end
                btms_pkg::OP_NOTE_START:
                begin
                    hz_reg         <= rd_reg[15:0];
                    drive_reg      <= 1'b1;
                    elapsed_reg    <= 32'd0;
                    start_next_reg <= 1'b0;
                end
                btms_pkg::OP_DUR_SET:
                begin
                    duration_reg <= neg_reg
                        ? 32'(quot_reg) + 32'(quot_reg >> 1)
                        : 32'(quot_reg);
                end
                btms_pkg::OP_COUNT:
                begin
                    if (elapsed_reg != 32'hFFFF_FFFF)
                    begin
                        elapsed_reg <= elapsed_reg + 32'd1;
                    end
                end
                btms_pkg::OP_FINISH:
                begin
                    drive_reg   <= 1'b0;
                    playing_reg <= 1'b0;
                    done_reg    <= 1'b1;
                end
                btms_pkg::OP_ADVANCE:
                begin
                    cursor_reg     <= cursor_reg + AW'(1);
                    start_next_reg <= 1'b1;
                end
                btms_pkg::OP_TONE:
                begin
                    melody_mode_reg <= 1'b0;
                    duration_reg    <= tone_dur_reg;
                    elapsed_reg     <= 32'd0;
                    playing_reg     <= 1'b1;
                    hz_reg          <= tone_freq_reg;
                    drive_reg       <= 1'b1;
                end
                btms_pkg::OP_MELODY:
                begin
                    melody_mode_reg <= 1'b1;
                    playing_reg     <= 1'b1;
                    count_reg       <= CW'(len_sat);
                    cursor_reg      <= '0;
                    start_next_reg  <= 1'b1;
                end
                btms_pkg::OP_STOP:
                begin
                    drive_reg   <= 1'b0;
                    playing_reg <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign tone_on    = tone_on_reg;
    assign tone_hz    = tone_hz_reg;
    assign is_playing = is_playing_reg;
    assign done_pulse = done_pulse_reg;

endmodule

`default_nettype wire
